// File: sv/dcw_pkg.sv
`default_nettype none
package dcw_pkg;

  localparam int unsigned ADDR_W  = 24;
  localparam int unsigned FETCH_W = 21;
  localparam int unsigned TOTAL_W = 30;
  localparam int unsigned COUNT_W = 22;
  localparam int unsigned HDR_W   = 32;

  localparam logic [ADDR_W-1:0]  ADDR_MASK   = 24'h1ffffc;
  localparam logic [ADDR_W-1:0]  END_MARK    = 24'hffffff;
  localparam logic [COUNT_W-1:0] LIMIT_RESET = 22'd2000000;
  localparam logic [COUNT_W-1:0] COUNT_MAX   = 22'h3fffff;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX   = 30'h3fffffff;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_NODE  = 1'b1;

  typedef enum logic [2:0] {
    ST_FETCH = 3'd0,
    ST_END   = 3'd1,
    ST_LOOP  = 3'd2,
    ST_LIMIT = 3'd3,
    ST_IDLE  = 3'd4
  } status_e;

  typedef struct packed {
    logic              cmd;
    logic [ADDR_W-1:0] start_addr;
    logic [HDR_W-1:0]  header_word;
  } item_t;

  typedef struct packed {
    status_e            status;
    logic [FETCH_W-1:0] fetch_addr;
    logic [TOTAL_W-1:0] total_words;
  } result_t;

endpackage
`default_nettype wire

// File: sv/dma_chain_length_walker.sv
// Each item passes the input register, the combinational walk core and the output
// register. Throughput: one item per cycle while the output is not stalled; the walk
// state updates in the single compute stage between the input and result registers.
// Reset: rst_ni is asynchronous, active low; it clears the walk state, the marks go
// to 0xffffff and the iteration limit returns to 2000000.
`default_nettype none
module dma_chain_length_walker (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic                        cmd_i,
  input  wire logic [dcw_pkg::ADDR_W-1:0]  start_addr_i,
  input  wire logic [dcw_pkg::HDR_W-1:0]   header_word_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [2:0]                       status_o,
  output logic [dcw_pkg::FETCH_W-1:0]      fetch_addr_o,
  output logic [dcw_pkg::TOTAL_W-1:0]      total_words_o,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [dcw_pkg::COUNT_W-1:0] cfg_iteration_limit_i
);
  import dcw_pkg::*;

  item_t   in_item;
  item_t   s1_item;
  logic    s1_valid;
  logic    res_ready;
  logic    advance;
  result_t s1_result;
  result_t out_result;

  assign in_item.cmd         = cmd_i;
  assign in_item.start_addr  = start_addr_i;
  assign in_item.header_word = header_word_i;

  assign advance     = s1_valid && res_ready;
  assign cfg_ready_o = 1'b1;

  dcw_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item),
    .valid_o    (s1_valid),
    .item_o     (s1_item),
    .drain_i    (advance)
  );

  dcw_walk_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .advance_i   (advance),
    .item_i      (s1_item),
    .result_o    (s1_result),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_limit_i (cfg_iteration_limit_i)
  );

  dcw_out_reg u_out_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s1_valid),
    .in_ready_o   (res_ready),
    .in_result_i  (s1_result),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_result_o (out_result)
  );

  assign status_o      = out_result.status;
  assign fetch_addr_o  = out_result.fetch_addr;
  assign total_words_o = out_result.total_words;

endmodule
`default_nettype wire

// File: sv/dcw_in_reg.sv
`default_nettype none
module dcw_in_reg (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire dcw_pkg::item_t in_item_i,
  output logic               valid_o,
  output dcw_pkg::item_t     item_o,
  input  wire logic          drain_i
);
  import dcw_pkg::*;

  logic  valid_q;
  item_t item_q;

  assign in_ready_o = !valid_q || drain_i;
  assign valid_o    = valid_q;
  assign item_o     = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_item_i;
    end
  end

endmodule
`default_nettype wire

// File: sv/dcw_walk_core.sv
`default_nettype none
module dcw_walk_core (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      advance_i,
  input  wire dcw_pkg::item_t            item_i,
  output dcw_pkg::result_t               result_o,
  input  wire logic                      cfg_we_i,
  input  wire logic [dcw_pkg::COUNT_W-1:0] cfg_limit_i
);
  import dcw_pkg::*;

  logic               walking_q, walking_d;
  logic [TOTAL_W-1:0] total_q, total_d;
  logic [COUNT_W-1:0] count_q, count_d;
  logic [ADDR_W-1:0]  last_q, last_d;
  logic [ADDR_W-1:0]  low_q, low_d;
  logic [ADDR_W-1:0]  high_q, high_d;
  logic [COUNT_W-1:0] limit_q;

  logic               is_start;
  logic [ADDR_W-1:0]  raw_addr;
  logic [ADDR_W-1:0]  addr;
  logic [COUNT_W-1:0] base_count;
  logic [ADDR_W-1:0]  base_last, base_low, base_high;
  logic [8:0]         add_words;
  logic [TOTAL_W:0]   sum;
  logic [TOTAL_W-1:0] sat_total;
  logic               limit_hit, loop_hit;
  status_e            visit_status;
  status_e            status;

  assign is_start   = (item_i.cmd == CMD_START);
  assign raw_addr   = is_start ? item_i.start_addr : item_i.header_word[ADDR_W-1:0];
  assign addr       = raw_addr & ADDR_MASK;
  assign base_count = is_start ? '0 : count_q;
  assign base_last  = is_start ? END_MARK : last_q;
  assign base_low   = is_start ? END_MARK : low_q;
  assign base_high  = is_start ? END_MARK : high_q;

  assign add_words = {1'b0, item_i.header_word[HDR_W-1:ADDR_W]} + 9'd1;
  assign sum       = {1'b0, total_q} + {{(TOTAL_W-8){1'b0}}, add_words};
  assign sat_total = (sum > {1'b0, TOTAL_MAX}) ? TOTAL_MAX : sum[TOTAL_W-1:0];

  assign limit_hit = (base_count > limit_q);
  assign loop_hit  = (addr == base_low) || (addr == base_high);

  always_comb begin
    walking_d    = walking_q;
    total_d      = total_q;
    count_d      = count_q;
    last_d       = last_q;
    low_d        = low_q;
    high_d       = high_q;
    visit_status = ST_FETCH;
    status       = ST_IDLE;

    if (limit_hit) begin
      visit_status = ST_LIMIT;
    end else if (loop_hit) begin
      visit_status = ST_LOOP;
    end

    if (is_start || walking_q) begin
      if (is_start) begin
        total_d = {{(TOTAL_W-1){1'b0}}, 1'b1};
      end else begin
        total_d = sat_total;
      end
      if (!is_start && item_i.header_word[ADDR_W-1:0] == END_MARK) begin
        walking_d = 1'b0;
        status    = ST_END;
      end else begin
        status  = visit_status;
        count_d = base_count;
        last_d  = base_last;
        low_d   = base_low;
        high_d  = base_high;
        if (!limit_hit && base_count != COUNT_MAX) begin
          count_d = base_count + {{(COUNT_W-1){1'b0}}, 1'b1};
        end
        if (visit_status == ST_FETCH) begin
          walking_d = 1'b1;
          last_d    = addr;
          if (addr < base_last) begin
            low_d = addr;
          end else begin
            high_d = addr;
          end
        end else begin
          walking_d = 1'b0;
        end
      end
    end
  end

  always_comb begin
    result_o.status      = status;
    result_o.fetch_addr  = (status == ST_FETCH) ? addr[FETCH_W-1:0] : '0;
    result_o.total_words = total_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      walking_q <= 1'b0;
      total_q   <= '0;
      count_q   <= '0;
      last_q    <= END_MARK;
      low_q     <= END_MARK;
      high_q    <= END_MARK;
    end else if (advance_i) begin
      walking_q <= walking_d;
      total_q   <= total_d;
      count_q   <= count_d;
      last_q    <= last_d;
      low_q     <= low_d;
      high_q    <= high_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
    end else if (cfg_we_i) begin
      limit_q <= cfg_limit_i;
    end
  end

endmodule
`default_nettype wire

// File: sv/dcw_out_reg.sv
`default_nettype none
module dcw_out_reg (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire dcw_pkg::result_t in_result_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output dcw_pkg::result_t      out_result_o
);
  import dcw_pkg::*;

  logic    valid_q;
  result_t result_q;

  assign in_ready_o   = !valid_q || out_ready_i;
  assign out_valid_o  = valid_q;
  assign out_result_o = result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      result_q <= in_result_i;
    end
  end

endmodule
`default_nettype wire

// File: sv/dcw_checker.sv
`default_nettype none
module dcw_checker (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        out_valid_o,
  input  wire logic                        out_ready_i,
  input  wire logic [2:0]                  status_o,
  input  wire logic [dcw_pkg::FETCH_W-1:0] fetch_addr_o,
  input  wire logic [dcw_pkg::TOTAL_W-1:0] total_words_o
);
  import dcw_pkg::*;

  a_fetch_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_FETCH |-> fetch_addr_o[1:0] == 2'b00)
    else $error("fetch address not word aligned");

  a_fetch_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_FETCH |-> fetch_addr_o == '0)
    else $error("fetch address set without fetch status");

  a_total_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_IDLE |-> total_words_o != '0)
    else $error("walk result with zero total");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o)
      && $stable(total_words_o))
    else $error("stalled result dropped or changed");

endmodule

bind dma_chain_length_walker dcw_checker u_dcw_checker (.*);
`default_nettype wire

// File: tb/dma_chain_length_walker_test.sv
`timescale 1ns / 100ps

module dma_chain_length_walker_test;
  import dcw_pkg::*;

  localparam int QUIET_LIMIT = 5000;
  localparam int HOLDOFF_CYCLES = 120;
  localparam int MAX_REPORTS = 30;

  typedef enum logic [1:0] {
    RX_FLOW,
    RX_COIN,
    RX_SPARSE,
    RX_BEAT
  } rx_mode_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic cmd_i = CMD_START;
  logic [ADDR_W-1:0] start_addr_i = '0;
  logic [HDR_W-1:0] header_word_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [2:0] status_o;
  logic [FETCH_W-1:0] fetch_addr_o;
  logic [TOTAL_W-1:0] total_words_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [COUNT_W-1:0] cfg_iteration_limit_i = '0;

  dma_chain_length_walker dut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .in_valid_i            (in_valid_i),
    .in_ready_o            (in_ready_o),
    .cmd_i                 (cmd_i),
    .start_addr_i          (start_addr_i),
    .header_word_i         (header_word_i),
    .out_valid_o           (out_valid_o),
    .out_ready_i           (out_ready_i),
    .status_o              (status_o),
    .fetch_addr_o          (fetch_addr_o),
    .total_words_o         (total_words_o),
    .cfg_valid_i           (cfg_valid_i),
    .cfg_ready_o           (cfg_ready_o),
    .cfg_iteration_limit_i (cfg_iteration_limit_i)
  );

  item_t   chain_items[$];
  result_t walk_reports_due[$];
  int      items_queued = 0;
  int      reports_seen = 0;
  int      fails = 0;
  logic    in_taken = 1'b0;
  int      holdoff_asks = 0;

  // walker state as the block should hold it
  logic [COUNT_W-1:0] limit_m = LIMIT_RESET;
  logic               walking_m = 1'b0;
  logic [TOTAL_W-1:0] total_m = '0;
  logic [COUNT_W-1:0] visits_m = '0;
  logic [ADDR_W-1:0]  last_m = END_MARK;
  logic [ADDR_W-1:0]  low_m = END_MARK;
  logic [ADDR_W-1:0]  high_m = END_MARK;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic status_e visit_node(input logic [ADDR_W-1:0] raw,
                                         output logic [FETCH_W-1:0] fetch);
    logic [ADDR_W-1:0] a;
    a = raw & ADDR_MASK;
    fetch = '0;
    if (visits_m > limit_m) begin
      walking_m = 1'b0;
      return ST_LIMIT;
    end
    if (visits_m != COUNT_MAX) visits_m = visits_m + 1'b1;
    if (a == low_m || a == high_m) begin
      walking_m = 1'b0;
      return ST_LOOP;
    end
    if (a < last_m) low_m = a;
    else high_m = a;
    last_m = a;
    fetch = a[FETCH_W-1:0];
    return ST_FETCH;
  endfunction

  function automatic result_t chain_step(input item_t it);
    result_t r;
    logic [31:0] add;
    logic [FETCH_W-1:0] fetch;
    fetch = '0;
    if (it.cmd == CMD_START) begin
      walking_m = 1'b1;
      total_m = TOTAL_W'(1);
      visits_m = '0;
      last_m = END_MARK;
      low_m = END_MARK;
      high_m = END_MARK;
      r.status = visit_node(it.start_addr, fetch);
    end else if (!walking_m) begin
      r.status = ST_IDLE;
    end else begin
      add = {24'd0, it.header_word[31:24]} + 32'd1;
      if ({2'b00, total_m} > {2'b00, TOTAL_MAX} - add) total_m = TOTAL_MAX;
      else total_m = total_m + add[TOTAL_W-1:0];
      if (it.header_word[ADDR_W-1:0] == END_MARK) begin
        walking_m = 1'b0;
        r.status = ST_END;
      end else begin
        r.status = visit_node(it.header_word[ADDR_W-1:0], fetch);
      end
    end
    r.fetch_addr = fetch;
    r.total_words = total_m;
    return r;
  endfunction

  task automatic note_mismatch(input string field, input longint want, input longint got);
    fails++;
    if (fails <= MAX_REPORTS) $error("%s: expected %0d, got %0d", field, want, got);
  endtask

  // input side: sample transfers, predict, check results
  always @(posedge clk_i) begin
    item_t   took;
    result_t want;
    in_taken = 1'b0;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        in_taken = 1'b1;
        took.cmd = cmd_i;
        took.start_addr = start_addr_i;
        took.header_word = header_word_i;
        walk_reports_due.push_back(chain_step(took));
      end
      if (out_valid_o && out_ready_i) begin
        reports_seen++;
        if (walk_reports_due.size() == 0) begin
          note_mismatch("unexpected result status", -1, status_o);
        end else begin
          want = walk_reports_due.pop_front();
          if (status_o !== want.status) note_mismatch("status", want.status, status_o);
          if (fetch_addr_o !== want.fetch_addr)
            note_mismatch("fetch_addr", want.fetch_addr, fetch_addr_o);
          if (total_words_o !== want.total_words)
            note_mismatch("total_words", want.total_words, total_words_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    int quiet;
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet = 0;
      end else begin
        quiet++;
        if (quiet >= QUIET_LIMIT) begin
          $display("CHECK FAILED");
          $finish;
        end
      end
    end else begin
      quiet = 0;
    end
  end

  // sender: bursts of random length, random gaps between them
  always @(negedge clk_i) begin
    item_t nxt;
    int burst_left;
    int gap_left;
    if (!rst_ni) begin
      burst_left = 1;
      gap_left = 0;
    end else if (in_valid_i && !in_taken) begin
      // hold the transfer until it is taken
    end else if (gap_left > 0) begin
      in_valid_i <= 1'b0;
      gap_left--;
    end else if (chain_items.size() == 0) begin
      in_valid_i <= 1'b0;
    end else begin
      nxt = chain_items.pop_front();
      in_valid_i <= 1'b1;
      cmd_i <= nxt.cmd;
      start_addr_i <= nxt.start_addr;
      header_word_i <= nxt.header_word;
      burst_left--;
      if (burst_left <= 0) begin
        burst_left = $urandom_range(1, 24);
        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      end
    end
  end

  // receiver: stall pattern that switches between random modes
  always @(negedge clk_i) begin
    rx_mode_e mode;
    int mode_left;
    int hold_left;
    int holdoff_done;
    int beat;
    beat++;
    if (hold_left > 0) begin
      out_ready_i <= 1'b0;
      hold_left--;
    end else if (holdoff_done != holdoff_asks) begin
      holdoff_done++;
      hold_left = HOLDOFF_CYCLES - 1;
      out_ready_i <= 1'b0;
    end else begin
      if (mode_left <= 0) begin
        mode = rx_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 96);
      end else begin
        mode_left--;
      end
      case (mode)
        RX_FLOW: out_ready_i <= 1'b1;
        RX_COIN: out_ready_i <= 1'($urandom_range(0, 1));
        RX_SPARSE: out_ready_i <= ($urandom_range(0, 3) == 0);
        default: out_ready_i <= (beat % 3 == 0);
      endcase
    end
  end

  task automatic push_item(input logic cmd, input logic [ADDR_W-1:0] sa,
                           input logic [HDR_W-1:0] hw);
    item_t it;
    it.cmd = cmd;
    it.start_addr = sa;
    it.header_word = hw;
    chain_items.push_back(it);
    items_queued++;
  endtask

  task automatic push_start(input logic [ADDR_W-1:0] sa);
    push_item(CMD_START, sa, $urandom);
  endtask

  task automatic push_node(input logic [HDR_W-1:0] hw);
    push_item(CMD_NODE, ADDR_W'($urandom_range(0, 32'hffffff)), hw);
  endtask

  task automatic wait_drained();
    do @(negedge clk_i); while (reports_seen != items_queued);
  endtask

  task automatic write_limit(input logic [COUNT_W-1:0] v);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_iteration_limit_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    limit_m = v;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [7:0] pick_count();
    case ($urandom_range(0, 3))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // keep the word-aligned offset, scramble the bits that the mask drops
  function automatic logic [ADDR_W-1:0] alias_addr(input logic [ADDR_W-1:0] masked);
    logic [ADDR_W-1:0] junk;
    junk = ADDR_W'($urandom_range(0, 32'hffffff));
    return masked | (junk & ~ADDR_MASK);
  endfunction

  task automatic random_walks(input int budget);
    logic [ADDR_W-1:0] trail[$];
    logic [ADDR_W-1:0] nxt;
    int made;
    int ending;
    made = 0;
    while (made < budget) begin
      if ($urandom_range(0, 9) == 0) begin
        push_node($urandom);
      end else begin
        trail.delete();
        nxt = ADDR_W'($urandom_range(0, 32'hffffff));
        trail.push_back(nxt & ADDR_MASK);
        push_start(nxt);
        made++;
        repeat ($urandom_range(0, 10)) begin
          if (trail.size() > 1 && $urandom_range(0, 5) == 0)
            nxt = alias_addr(trail[$urandom_range(0, trail.size() - 1)]);
          else
            nxt = ADDR_W'($urandom_range(0, 32'hffffff));
          push_node({pick_count(), nxt});
          trail.push_back(nxt & ADDR_MASK);
          made++;
        end
        ending = $urandom_range(0, 9);
        if (ending < 5) begin
          push_node({pick_count(), END_MARK});
          made++;
        end else if (ending < 7) begin
          push_node({pick_count(), alias_addr(trail[$urandom_range(0, trail.size() - 1)])});
          made++;
        end else if (ending > 7) begin
          push_node({pick_count(), END_MARK});
          made++;
          repeat ($urandom_range(1, 3)) push_node($urandom);
        end
      end
    end
  endtask

  initial begin
    logic [COUNT_W-1:0] lim;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    push_node(32'h5a001234);
    push_start(24'hffffff);
    push_node(32'h00000000);
    push_node(32'hffe00003);
    push_node(32'hffffffff);
    push_start(24'h000000);
    push_node(32'h12fffffe);
    push_node(32'h01000040);
    push_start(24'habcdef);
    push_node(32'h7f0dcdec);
    push_start(24'h000100);
    push_node(32'h00000200);
    push_node(32'h00000080);
    push_node(32'h00000100);
    push_node(32'h80ffffff);
    wait_drained();

    write_limit('0);
    push_start(24'h000010);
    push_node(32'h00000020);
    push_node(32'h00000030);
    wait_drained();

    write_limit(22'd1);
    push_start(24'h000010);
    push_node(32'h03000020);
    push_node(32'h00000030);
    wait_drained();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: lim = COUNT_MAX;
        1: lim = COUNT_W'($urandom_range(2, 12));
        2: lim = COUNT_W'($urandom_range(0, 32'h3fffff));
        3: lim = '0;
        4: lim = COUNT_W'($urandom_range(1, 6));
        default: lim = LIMIT_RESET;
      endcase
      write_limit(lim);
      holdoff_asks <= holdoff_asks + 1;
      random_walks(45);
      wait_drained();
      random_walks(45);
      wait_drained();
    end

    repeat (8) @(posedge clk_i);
    if (walk_reports_due.size() != 0) begin
      fails++;
      $error("%0d results never arrived", walk_reports_due.size());
    end
    if (fails == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/dcw_pkg.sv
sv/dcw_in_reg.sv
sv/dcw_walk_core.sv
sv/dcw_out_reg.sv
sv/dma_chain_length_walker.sv
sv/dcw_checker.sv
tb/dma_chain_length_walker_test.sv
